// File: design/tavm_pkg.sv
package tavm_pkg;

  localparam int unsigned SampleWidth = 16;
  localparam int unsigned FracBits = 8;
  localparam int unsigned MagWidth = 24;

  // Widths of the arithmetic path, derived from the sample width and FracBits.
  localparam int unsigned SquareWidth = 2 * SampleWidth - 1;
  localparam int unsigned SumWidth = 2 * SampleWidth;
  localparam int unsigned RadWidth = SumWidth + 2 * FracBits;
  localparam int unsigned RootWidth = RadWidth / 2;
  localparam int unsigned RemWidth = RootWidth + 2;

  localparam int unsigned SqrtBitsPerStage = 2;
  localparam int unsigned SqrtStages = RootWidth / SqrtBitsPerStage;

  localparam int unsigned CfgIndexWidth = 2;
  localparam logic DoneBit = 1'b1;

  typedef enum logic [CfgIndexWidth-1:0] {
    CfgIntOneEnable = 2'd0,
    CfgIntTwoEnable = 2'd1
  } cfg_reg_e;

  typedef struct packed {
    logic signed [SampleWidth-1:0] axis_x;
    logic signed [SampleWidth-1:0] axis_y;
    logic signed [SampleWidth-1:0] axis_z;
  } in_item_t;

  typedef struct packed {
    logic signed [SampleWidth-1:0] out_x;
    logic signed [SampleWidth-1:0] out_y;
    logic signed [SampleWidth-1:0] out_z;
    logic [MagWidth-1:0]           magnitude;
    logic                          done_flag;
    logic                          irq_one;
    logic                          irq_two;
  } out_item_t;

  typedef struct packed {
    logic [RemWidth-1:0]  rem;
    logic [RootWidth-1:0] root;
    logic [RadWidth-1:0]  rad;
  } sqrt_work_t;

endpackage

// File: design/tavm_square.sv
module tavm_square (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 en_i,
  input  logic                                 valid_i,
  input  tavm_pkg::in_item_t                   item_i,
  output logic                                 valid_o,
  output tavm_pkg::in_item_t                   item_o,
  output logic [tavm_pkg::SumWidth-1:0]        sum_o
);

  localparam int unsigned Sw = tavm_pkg::SampleWidth;

  logic [Sw-1:0] abs_x, abs_y, abs_z;
  logic [2*Sw-1:0] prod_x, prod_y, prod_z;
  logic [tavm_pkg::SquareWidth-1:0] sq_x_q, sq_y_q, sq_z_q;
  logic valid_a_q, valid_b_q;
  tavm_pkg::in_item_t item_a_q, item_b_q;
  logic [tavm_pkg::SumWidth-1:0] sum_d, sum_q;

  function automatic logic [Sw-1:0] abs_val(input logic [Sw-1:0] v);
    logic [Sw:0] neg;
    neg = -{v[Sw-1], v};
    return v[Sw-1] ? neg[Sw-1:0] : v;
  endfunction

  assign abs_x = abs_val(item_i.axis_x);
  assign abs_y = abs_val(item_i.axis_y);
  assign abs_z = abs_val(item_i.axis_z);

  assign prod_x = abs_x * abs_x;
  assign prod_y = abs_y * abs_y;
  assign prod_z = abs_z * abs_z;

  assign sum_d = tavm_pkg::SumWidth'(sq_x_q) + tavm_pkg::SumWidth'(sq_y_q)
               + tavm_pkg::SumWidth'(sq_z_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_a_q <= 1'b0;
      valid_b_q <= 1'b0;
    end else if (en_i) begin
      valid_a_q <= valid_i;
      valid_b_q <= valid_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sq_x_q   <= prod_x[tavm_pkg::SquareWidth-1:0];
      sq_y_q   <= prod_y[tavm_pkg::SquareWidth-1:0];
      sq_z_q   <= prod_z[tavm_pkg::SquareWidth-1:0];
      item_a_q <= item_i;
      sum_q    <= sum_d;
      item_b_q <= item_a_q;
    end
  end

  assign valid_o = valid_b_q;
  assign item_o  = item_b_q;
  assign sum_o   = sum_q;

endmodule

// File: design/tavm_sqrt_stage.sv
module tavm_sqrt_stage (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  tavm_pkg::in_item_t   item_i,
  input  tavm_pkg::sqrt_work_t work_i,
  output logic                 valid_o,
  output tavm_pkg::in_item_t   item_o,
  output tavm_pkg::sqrt_work_t work_o
);

  localparam int unsigned RemW = tavm_pkg::RemWidth;
  localparam int unsigned RootW = tavm_pkg::RootWidth;
  localparam int unsigned RadW = tavm_pkg::RadWidth;

  logic [RemW+1:0] shifted, trial, diff;
  tavm_pkg::sqrt_work_t work_d, work_q;
  tavm_pkg::in_item_t item_q;
  logic valid_q;

  // Restoring square root, two radicand bits per result bit.
  always_comb begin
    work_d  = work_i;
    shifted = '0;
    trial   = '0;
    diff    = '0;
    for (int i = 0; i < tavm_pkg::SqrtBitsPerStage; i++) begin
      shifted = {work_d.rem, work_d.rad[RadW-1 -: 2]};
      trial   = {2'b00, work_d.root, 2'b01};
      diff    = shifted - trial;
      if (shifted >= trial) begin
        work_d.rem  = diff[RemW-1:0];
        work_d.root = {work_d.root[RootW-2:0], 1'b1};
      end else begin
        work_d.rem  = shifted[RemW-1:0];
        work_d.root = {work_d.root[RootW-2:0], 1'b0};
      end
      work_d.rad = {work_d.rad[RadW-3:0], 2'b00};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      work_q <= work_d;
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;
  assign work_o  = work_q;

endmodule

// File: design/tavm_skid.sv
module tavm_skid (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                ready_o,
  input  tavm_pkg::out_item_t item_i,
  output logic                valid_o,
  input  logic                ready_i,
  output tavm_pkg::out_item_t item_o
);

  logic out_valid_q, skid_valid_q;
  tavm_pkg::out_item_t out_q, skid_q;
  logic take, out_free;

  assign ready_o  = !skid_valid_q;
  assign take     = valid_i && !skid_valid_q;
  assign out_free = !out_valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      // The held item goes first; while it is held no new item is taken.
      out_valid_q  <= skid_valid_q || take;
      skid_valid_q <= 1'b0;
    end else if (take) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_q <= skid_valid_q ? skid_q : item_i;
    end else if (take) begin
      skid_q <= item_i;
    end
  end

  assign valid_o = out_valid_q;
  assign item_o  = out_q;

endmodule

// File: design/three_axis_vector_magnitude.sv
// Pipeline: two register stages for abs/square/sum, twelve square root
// stages at two bits a stage, and one output register.
// Throughput: one item per cycle; input stalls only when two results wait.
// Reset is asynchronous, active low; it empties the pipeline and clears both
// interrupt enables.
module three_axis_vector_magnitude (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  tavm_pkg::in_item_t                  in_item_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output tavm_pkg::out_item_t                 out_item_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [tavm_pkg::CfgIndexWidth-1:0]  cfg_index_i,
  input  logic                                cfg_data_i
);

  localparam int unsigned Stages = tavm_pkg::SqrtStages;

  logic en;
  logic int_one_enable_q, int_two_enable_q;
  logic sq_valid;
  tavm_pkg::in_item_t sq_item;
  logic [tavm_pkg::SumWidth-1:0] sq_sum;

  logic                 st_valid [Stages+1];
  tavm_pkg::in_item_t   st_item  [Stages+1];
  tavm_pkg::sqrt_work_t st_work  [Stages+1];

  tavm_pkg::out_item_t result;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      int_one_enable_q <= 1'b0;
      int_two_enable_q <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        tavm_pkg::CfgIntOneEnable: int_one_enable_q <= cfg_data_i;
        tavm_pkg::CfgIntTwoEnable: int_two_enable_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_ready_o = en;

  tavm_square u_square (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .item_i  (in_item_i),
    .valid_o (sq_valid),
    .item_o  (sq_item),
    .sum_o   (sq_sum)
  );

  assign st_valid[0]     = sq_valid;
  assign st_item[0]      = sq_item;
  assign st_work[0].rem  = '0;
  assign st_work[0].root = '0;
  assign st_work[0].rad  = tavm_pkg::RadWidth'(sq_sum) << (2 * tavm_pkg::FracBits);

  for (genvar g = 0; g < Stages; g++) begin : g_sqrt
    tavm_sqrt_stage u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (st_valid[g]),
      .item_i  (st_item[g]),
      .work_i  (st_work[g]),
      .valid_o (st_valid[g+1]),
      .item_o  (st_item[g+1]),
      .work_o  (st_work[g+1])
    );
  end

  always_comb begin
    result.out_x     = st_item[Stages].axis_x;
    result.out_y     = st_item[Stages].axis_y;
    result.out_z     = st_item[Stages].axis_z;
    result.magnitude = st_work[Stages].root[tavm_pkg::MagWidth-1:0];
    result.done_flag = tavm_pkg::DoneBit;
    result.irq_one   = tavm_pkg::DoneBit & int_one_enable_q;
    result.irq_two   = tavm_pkg::DoneBit & int_two_enable_q;
  end

  tavm_skid u_skid (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (st_valid[Stages]),
    .ready_o (en),
    .item_i  (result),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .item_o  (out_item_o)
  );

endmodule

// File: design/tavm_checker.sv
module tavm_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_ready_o,
  input logic                                out_valid_o,
  input logic                                out_ready_i,
  input tavm_pkg::out_item_t                 out_item_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("result item changed or dropped while stalled");

  a_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_item_o.done_flag)
    else $error("done flag low on a result item");

  // The input side only stalls when results are backed up on the output.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && $past(out_valid_o && !out_ready_i))
    else $error("input stalled without a waiting result");

  a_zero_mag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.out_x == '0 && out_item_o.out_y == '0
      && out_item_o.out_z == '0 |-> out_item_o.magnitude == '0)
    else $error("nonzero magnitude for a zero vector");

endmodule

bind three_axis_vector_magnitude tavm_checker u_tavm_checker (.*);
